// ===== hdl/rar_pkg.sv =====
package rar_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned WideWidth    = 64;
  localparam int unsigned DenWidth     = 62;
  localparam int unsigned CountWidth   = $clog2(WideWidth + 1);

  typedef logic [OperandWidth-1:0]   opnd_t;
  typedef logic [2*OperandWidth-1:0] prod_t;
  typedef logic [WideWidth-1:0]      wide_t;

  typedef struct packed {
    logic  start;
    wide_t dividend;
    wide_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    wide_t quotient;
    wide_t remainder;
  } div_rsp_t;

endpackage

// ===== hdl/rar_div.sv =====
module rar_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rar_pkg::div_req_t  req_i,
  output rar_pkg::div_rsp_t  rsp_o
);
  import rar_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CountWidth-1:0] cnt_q, cnt_d;
  wide_t                 rem_q, rem_d;
  wide_t                 quo_q, quo_d;
  wide_t                 dsr_q, dsr_d;

  logic [WideWidth:0] shifted;
  logic [WideWidth:0] diff;

  always_comb begin
    shifted = {rem_q, quo_q[WideWidth-1]};
    diff    = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (busy_q) begin
      if (!diff[WideWidth]) begin
        rem_d = diff[WideWidth-1:0];
        quo_d = {quo_q[WideWidth-2:0], 1'b1};
      end else begin
        rem_d = shifted[WideWidth-1:0];
        quo_d = {quo_q[WideWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CountWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CountWidth'(WideWidth);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ===== hdl/rar_mul.sv =====
module rar_mul (
  input  rar_pkg::opnd_t a_i,
  input  rar_pkg::opnd_t b_i,
  output rar_pkg::prod_t p_o
);
  import rar_pkg::*;

  assign p_o = prod_t'(a_i) * prod_t'(b_i);

endmodule

// ===== hdl/rational_add_reduce.sv =====
// Channel   Direction  Ports                                            Handshake
// command   in         a_numerator_i a_denominator_i b_numerator_i      start_i & !busy_o
//                      b_denominator_i
// result    out        sum_numerator_o sum_denominator_o                done_o, one cycle
//                      zero_denominator_error_o
//
// One transaction runs through three fraction reductions (operand a, operand b, sum),
// each a Euclidean GCD followed by two exact divisions, all on one shared 64-bit
// radix-2 divider that takes a new division only once the last one is done; the
// run time grows with the remainder step count of each GCD, and the multiply states
// ST_MUL_A, ST_MUL_B and ST_MUL_D are added when the reduced denominators differ.
// Reset clears the sequencer and divider; busy_o stays high until the result strobe.
// The result stays on the ports until the next result strobe; the receiver cannot stall.
module rational_add_reduce (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic [rar_pkg::OperandWidth-1:0] a_numerator_i,
  input  logic [rar_pkg::OperandWidth-1:0] a_denominator_i,
  input  logic [rar_pkg::OperandWidth-1:0] b_numerator_i,
  input  logic [rar_pkg::OperandWidth-1:0] b_denominator_i,
  output logic                             done_o,
  output logic [rar_pkg::WideWidth-1:0]    sum_numerator_o,
  output logic [rar_pkg::DenWidth-1:0]     sum_denominator_o,
  output logic                             zero_denominator_error_o
);
  import rar_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_DIV_NUM,
    ST_DIV_DEN,
    ST_REDUCED,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_SUM
  } state_e;

  typedef enum logic [1:0] {
    PH_A,
    PH_B,
    PH_S
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  wide_t  num_q, den_q, x_q, y_q;
  logic   neg_q;
  opnd_t  an_q, ad_q, bn_q, bd_q;
  logic   aneg_q, bneg_q;
  wide_t  ta_q, tb_q, sd_q;
  logic   err_q;
  logic   done_q;
  wide_t  sum_num_q;
  logic [DenWidth-1:0] sum_den_q;
  logic   sum_err_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  opnd_t    mul_a, mul_b;
  prod_t    mul_p;

  opnd_t an_mag, ad_mag, bn_mag, bd_mag;
  logic  an_neg, ad_neg, bn_neg, bd_neg;
  logic  ad_zero, bd_zero;

  logic  sum_neg;
  wide_t sum_mag;
  logic  red_neg;

  rar_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rar_mul u_mul (
    .a_i (mul_a),
    .b_i (mul_b),
    .p_o (mul_p)
  );

  always_comb begin
    an_neg  = a_numerator_i[OperandWidth-1];
    an_mag  = an_neg ? (~a_numerator_i + 1'b1) : a_numerator_i;
    ad_zero = (a_denominator_i == '0);
    ad_neg  = a_denominator_i[OperandWidth-1];
    ad_mag  = ad_zero ? opnd_t'(1) :
              (ad_neg ? (~a_denominator_i + 1'b1) : a_denominator_i);
    bn_neg  = b_numerator_i[OperandWidth-1];
    bn_mag  = bn_neg ? (~b_numerator_i + 1'b1) : b_numerator_i;
    bd_zero = (b_denominator_i == '0);
    bd_neg  = b_denominator_i[OperandWidth-1];
    bd_mag  = bd_zero ? opnd_t'(1) :
              (bd_neg ? (~b_denominator_i + 1'b1) : b_denominator_i);
  end

  always_comb begin
    div_req = '0;
    case (state_q)
      ST_GCD_CHK: begin
        div_req.start = 1'b1;
        if (y_q != '0) begin
          div_req.dividend = x_q;
          div_req.divisor  = y_q;
        end else begin
          div_req.dividend = num_q;
          div_req.divisor  = x_q;
        end
      end
      ST_DIV_NUM: begin
        div_req.start    = div_rsp.done;
        div_req.dividend = den_q;
        div_req.divisor  = x_q;
      end
      default: div_req = '0;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_MUL_A: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
      ST_MUL_B: begin
        mul_a = bn_q;
        mul_b = ad_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
    endcase
  end

  always_comb begin
    if (aneg_q == bneg_q) begin
      sum_neg = aneg_q;
      sum_mag = ta_q + tb_q;
    end else if (ta_q >= tb_q) begin
      sum_neg = aneg_q;
      sum_mag = ta_q - tb_q;
    end else begin
      sum_neg = bneg_q;
      sum_mag = tb_q - ta_q;
    end
    red_neg = neg_q && (num_q != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_A;
      num_q     <= '0;
      den_q     <= '0;
      x_q       <= '0;
      y_q       <= '0;
      neg_q     <= 1'b0;
      an_q      <= '0;
      ad_q      <= '0;
      bn_q      <= '0;
      bd_q      <= '0;
      aneg_q    <= 1'b0;
      bneg_q    <= 1'b0;
      ta_q      <= '0;
      tb_q      <= '0;
      sd_q      <= '0;
      err_q     <= 1'b0;
      done_q    <= 1'b0;
      sum_num_q <= '0;
      sum_den_q <= '0;
      sum_err_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            phase_q <= PH_A;
            num_q   <= wide_t'(an_mag);
            den_q   <= wide_t'(ad_mag);
            x_q     <= wide_t'(an_mag);
            y_q     <= wide_t'(ad_mag);
            neg_q   <= an_neg ^ (ad_neg && !ad_zero);
            bn_q    <= bn_mag;
            bd_q    <= bd_mag;
            bneg_q  <= bn_neg ^ (bd_neg && !bd_zero);
            err_q   <= ad_zero || bd_zero;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_GCD_CHK: begin
          state_q <= (y_q != '0) ? ST_GCD_WAIT : ST_DIV_NUM;
        end
        ST_GCD_WAIT: begin
          if (div_rsp.done) begin
            x_q     <= y_q;
            y_q     <= div_rsp.remainder;
            state_q <= ST_GCD_CHK;
          end
        end
        ST_DIV_NUM: begin
          if (div_rsp.done) begin
            num_q   <= div_rsp.quotient;
            state_q <= ST_DIV_DEN;
          end
        end
        ST_DIV_DEN: begin
          if (div_rsp.done) begin
            den_q   <= div_rsp.quotient;
            state_q <= ST_REDUCED;
          end
        end
        ST_REDUCED: begin
          case (phase_q)
            PH_A: begin
              an_q    <= num_q[OperandWidth-1:0];
              ad_q    <= den_q[OperandWidth-1:0];
              aneg_q  <= red_neg;
              num_q   <= wide_t'(bn_q);
              den_q   <= wide_t'(bd_q);
              x_q     <= wide_t'(bn_q);
              y_q     <= wide_t'(bd_q);
              neg_q   <= bneg_q;
              phase_q <= PH_B;
              state_q <= ST_GCD_CHK;
            end
            PH_B: begin
              bn_q   <= num_q[OperandWidth-1:0];
              bd_q   <= den_q[OperandWidth-1:0];
              bneg_q <= red_neg;
              if (ad_q != den_q[OperandWidth-1:0]) begin
                state_q <= ST_MUL_A;
              end else begin
                ta_q    <= wide_t'(an_q);
                tb_q    <= num_q;
                sd_q    <= wide_t'(ad_q);
                state_q <= ST_SUM;
              end
            end
            default: begin
              sum_num_q <= red_neg ? (wide_t'(0) - num_q) : num_q;
              sum_den_q <= den_q[DenWidth-1:0];
              sum_err_q <= err_q;
              done_q    <= 1'b1;
              state_q   <= ST_IDLE;
            end
          endcase
        end
        ST_MUL_A: begin
          ta_q    <= wide_t'(mul_p);
          state_q <= ST_MUL_B;
        end
        ST_MUL_B: begin
          tb_q    <= wide_t'(mul_p);
          state_q <= ST_MUL_D;
        end
        ST_MUL_D: begin
          sd_q    <= wide_t'(mul_p);
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          num_q   <= sum_mag;
          den_q   <= sd_q;
          x_q     <= sum_mag;
          y_q     <= sd_q;
          neg_q   <= sum_neg;
          phase_q <= PH_S;
          state_q <= ST_GCD_CHK;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o                   = (state_q != ST_IDLE);
  assign done_o                   = done_q;
  assign sum_numerator_o          = sum_num_q;
  assign sum_denominator_o        = sum_den_q;
  assign zero_denominator_error_o = sum_err_q;

endmodule
